@@ rtl/spf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_pkg
// Types and constants shared by the stride prefetcher and its line cells.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int SPF_FIELD_W     = 48;
    localparam int SPF_CFG_W       = 7;
    localparam int SPF_IDX_W       = 10;   // holds any line index or age up to 1023
    localparam int SPF_CACHE_LINES = 64;
    localparam int SPF_TABLE_ENTS  = 64;
    localparam int SPF_ADDR_BITS   = 48;
    localparam logic [SPF_CFG_W-1:0] SPF_LINES_RESET = 7'd64;

    typedef struct packed {
        logic [SPF_FIELD_W-1:0] load_address;
        logic [SPF_FIELD_W-1:0] instr_pointer;
    } t_in_item;

    typedef struct packed {
        logic                   demand_hit;
        logic                   prefetch_hit;
        logic                   prefetch_issued;
        logic [SPF_FIELD_W-1:0] prefetch_address;
    } t_out_item;

    // Result of a search wave, accumulated from line 0 upwards.
    typedef struct packed {
        logic                 mfound;
        logic [SPF_IDX_W-1:0] midx;
        logic [SPF_IDX_W-1:0] mage;
        logic                 mpf;
        logic                 ifound;
        logic [SPF_IDX_W-1:0] iidx;
        logic [SPF_IDX_W-1:0] bage;
        logic [SPF_IDX_W-1:0] bidx;
    } t_agg;

    // Command broadcast to every line cell.
    typedef struct packed {
        logic                 clear;
        logic                 upd;
        logic                 fill;
        logic                 pf;
        logic [SPF_IDX_W-1:0] idx;
        logic [SPF_IDX_W-1:0] age;
    } t_cmd;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WAVE1,
        S_UPD1,
        S_TABLE,
        S_STRIDE,
        S_WAVE2,
        S_UPD2,
        S_FIN
    } t_state;

endpackage

@@ rtl/spf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module spf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/spf_mod.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_mod
// Remainder of the instruction pointer by the table size, through a registered folded sum, quotient and remainder.
// ----------------------------------------------------------------------------
module spf_mod #(
    parameter int TABLE_ENTRIES = spf_pkg::SPF_TABLE_ENTS,
    parameter int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [spf_pkg::SPF_FIELD_W-1:0] i_ip,
    output logic                         o_done,
    output logic [TW-1:0]                o_rem
);
    import spf_pkg::*;

    localparam int SW   = 26;
    localparam int LW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 0;
    localparam int MULW = SW + 2;
    localparam int PW   = SW + MULW;
    localparam int QW   = SW + 13;
    localparam logic [63:0] M64   = 64'(TABLE_ENTRIES);
    localparam logic [63:0] MUL64 = ((64'd1 << (SW + LW)) + M64 - 64'd1) / M64;
    localparam logic [MULW-1:0] MUL = MULW'(MUL64);
    localparam logic [12:0] DIV = 13'(TABLE_ENTRIES);
    localparam logic [11:0] R0  = 12'(64'd1 % M64);
    localparam logic [11:0] R1  = 12'((64'd1 << 12) % M64);
    localparam logic [11:0] R2  = 12'((64'd1 << 24) % M64);
    localparam logic [11:0] R3  = 12'((64'd1 << 36) % M64);

    logic [23:0]   w_p0, w_p1, w_p2, w_p3;
    logic [SW-1:0] w_fold, w_q, w_rsub;
    logic [PW-1:0] w_prod;
    logic [QW-1:0] w_qm;
    logic [SW-1:0] r_sum, r_q;
    logic [TW-1:0] r_rem;
    logic [1:0]    r_cnt;

    // Each 12-bit slice is weighted by its place value reduced by the table size,
    // which leaves a sum small enough for an exact reciprocal multiplication.
    assign w_p0   = i_ip[11:0]  * R0;
    assign w_p1   = i_ip[23:12] * R1;
    assign w_p2   = i_ip[35:24] * R2;
    assign w_p3   = i_ip[47:36] * R3;
    assign w_fold = SW'(w_p0) + SW'(w_p1) + SW'(w_p2) + SW'(w_p3);

    assign w_prod = PW'(r_sum) * PW'(MUL);
    assign w_q    = SW'(w_prod >> (SW + LW));
    assign w_qm   = QW'(r_q) * QW'(DIV);
    assign w_rsub = r_sum - w_qm[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 2'd2;
        end else if (r_cnt != 2'd0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sum <= w_fold;
        end
        if (r_cnt == 2'd2) begin
            r_q <= w_q;
        end
        if (r_cnt == 2'd1) begin
            r_rem <= w_rsub[TW-1:0];
        end
    end

    assign o_done = (r_cnt == 2'd0) && !i_start;
    assign o_rem  = r_rem;

endmodule

@@ rtl/spf_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_cell
// One cache line: address, valid, prefetched mark and age, plus one stage
// of the search wave that runs from line 0 to the last line.
// ----------------------------------------------------------------------------
module spf_cell #(
    parameter int CACHE_LINES = spf_pkg::SPF_CACHE_LINES,
    parameter int ADDR_BITS   = spf_pkg::SPF_ADDR_BITS,
    parameter int INDEX       = 0,
    parameter int CW          = $clog2(CACHE_LINES + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  spf_pkg::t_cmd        i_cmd,
    input  logic [ADDR_BITS-1:0] i_key,
    input  logic [CW-1:0]        i_n_lines,
    input  spf_pkg::t_agg        i_agg,
    output spf_pkg::t_agg        o_agg
);
    import spf_pkg::*;

    localparam int AGW = $clog2(CACHE_LINES);
    localparam logic [AGW-1:0] AGE_MAX = AGW'(CACHE_LINES - 1);

    logic [ADDR_BITS-1:0] r_addr;
    logic                 r_valid, r_pf;
    logic [AGW-1:0]       r_age;
    t_agg                 r_agg, w_agg;
    logic                 w_active, w_match, w_self;

    assign w_active = i_n_lines > CW'(INDEX);
    assign w_match  = w_active && r_valid && (r_addr == i_key);
    assign w_self   = i_cmd.idx == SPF_IDX_W'(INDEX);

    // Fold this line into the partial result from the lower lines.
    always_comb begin
        w_agg = i_agg;
        if (!i_agg.mfound && w_match) begin
            w_agg.mfound = 1'b1;
            w_agg.midx   = SPF_IDX_W'(INDEX);
            w_agg.mage   = SPF_IDX_W'(r_age);
            w_agg.mpf    = r_pf;
        end
        if (w_active && !r_valid && !i_agg.ifound) begin
            w_agg.ifound = 1'b1;
            w_agg.iidx   = SPF_IDX_W'(INDEX);
        end
        if (w_active && (SPF_IDX_W'(r_age) > i_agg.bage)) begin
            w_agg.bage = SPF_IDX_W'(r_age);
            w_agg.bidx = SPF_IDX_W'(INDEX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_agg <= '0;
        end else if (i_cmd.clear) begin
            r_agg <= '0;
        end else begin
            r_agg <= w_agg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pf    <= 1'b0;
            r_age   <= '0;
        end else if (i_cmd.upd) begin
            if (w_self) begin
                r_age <= '0;
                r_pf  <= i_cmd.pf;
                if (i_cmd.fill) begin
                    r_valid <= 1'b1;
                end
            end else if (w_active && r_valid && (SPF_IDX_W'(r_age) < i_cmd.age)
                         && (r_age < AGE_MAX)) begin
                r_age <= r_age + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && i_cmd.fill && w_self) begin
            r_addr <= i_key;
        end
    end

    assign o_agg = r_agg;

endmodule

@@ rtl/stride_prefetcher_lru_cache_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stride_prefetcher_lru_cache_unit
// Stride prefetcher feeding a fully associative LRU cache of line cells.
// ----------------------------------------------------------------------------
// Loads enter on the input channel (valid/ready) as an address and the
// instruction pointer that issued them; each gives exactly one result item
// on the output channel (valid/ready) with the hit flags and any prefetch.
// The lines_in_use register is written through i_cfg_we / i_cfg_data; the user must
// write it only while the block is idle, which the block itself does not enforce.
// The cache lines form a row of cells; a lookup is a wave that moves one
// cell per cycle. The stride table index is found alongside it by folding
// the instruction pointer and a reciprocal multiplication.
// A result item also waits for a second lookup wave when its stride repeats
// and the prefetch target must be looked up.
// One item is handled at a time; a finished result waits in the output
// register while the next item is taken, and a stalled receiver holds back
// only the completion of that next item.
// After reset the stride table is cleared one entry per cycle, and no item
// is accepted until every entry has been cleared.
// ----------------------------------------------------------------------------
module stride_prefetcher_lru_cache_unit #(
    parameter int CACHE_LINES   = spf_pkg::SPF_CACHE_LINES,
    parameter int TABLE_ENTRIES = spf_pkg::SPF_TABLE_ENTS,
    parameter int ADDR_BITS     = spf_pkg::SPF_ADDR_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  spf_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output spf_pkg::t_out_item              o_out_item,
    input  logic                            i_cfg_we,
    input  logic [spf_pkg::SPF_CFG_W-1:0]   i_cfg_data
);
    import spf_pkg::*;

    localparam int CW  = $clog2(CACHE_LINES + 1);
    localparam int TW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int EW  = 2 + SPF_FIELD_W + 2 * ADDR_BITS;
    localparam logic [SPF_IDX_W-1:0] AGE_MAX = SPF_IDX_W'(CACHE_LINES - 1);

    t_state r_state, n_state;

    logic [SPF_CFG_W-1:0]   r_lines;
    logic [31:0]            w_lines32;
    logic [CW-1:0]          w_n_lines;
    logic [ADDR_BITS-1:0]   r_addr, r_key, r_diff;
    logic [SPF_FIELD_W-1:0] r_ip;
    logic                   r_pfcond;
    logic [CW-1:0]          r_cnt;
    logic [TW-1:0]          r_clr;
    logic                   r_dhit, r_phit, r_issued;
    logic [ADDR_BITS-1:0]   r_paddr;
    logic                   r_out_valid;
    t_out_item              r_out_item;

    t_cmd                   w_cmd;
    t_agg                   w_agg [CACHE_LINES + 1];
    t_agg                   w_res;
    logic                   w_accept, w_mod_start, w_mod_done;
    logic [TW-1:0]          w_rem;
    logic                   w_we;
    logic [TW-1:0]          w_waddr;
    logic [EW-1:0]          w_wdata, w_rdata;

    logic                   w_tvalid, w_tborrow, w_tmiss;
    logic [SPF_FIELD_W-1:0] w_ttag;
    logic [ADDR_BITS-1:0]   w_tlast, w_tstride, w_diff;
    logic                   w_borrow;

    assign w_lines32 = 32'(r_lines);
    assign w_n_lines = (w_lines32 == 32'd0) ? CW'(1) :
                       (w_lines32 > 32'(CACHE_LINES)) ? CW'(CACHE_LINES) : CW'(w_lines32);

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_mod_start = w_accept;
    assign w_res       = w_agg[CACHE_LINES];

    assign {w_tvalid, w_ttag, w_tlast, w_tstride, w_tborrow} = w_rdata;
    assign w_tmiss  = !w_tvalid || (w_ttag != r_ip);
    assign w_diff   = r_addr - w_tlast;
    assign w_borrow = r_addr < w_tlast;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == TW'(TABLE_ENTRIES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) n_state = S_WAVE1;
            end
            S_WAVE1: begin
                if (r_cnt == CW'(CACHE_LINES) && w_mod_done) n_state = S_UPD1;
            end
            S_UPD1:   n_state = S_TABLE;
            S_TABLE:  n_state = S_STRIDE;
            S_STRIDE: n_state = r_pfcond ? S_WAVE2 : S_FIN;
            S_WAVE2: begin
                if (r_cnt == CW'(CACHE_LINES)) n_state = S_UPD2;
            end
            S_UPD2:   n_state = S_FIN;
            S_FIN: begin
                if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            end
            default:  n_state = S_CLEAR;
        endcase
    end

    // Control outputs per state.
    always_comb begin
        o_in_ready = 1'b0;
        w_cmd      = '0;
        w_we       = 1'b0;
        w_waddr    = w_rem;
        w_wdata    = {1'b1, r_ip, r_addr, ADDR_BITS'(0), 1'b0};
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
            end
            S_IDLE: begin
                o_in_ready  = 1'b1;
                w_cmd.clear = w_accept;
            end
            S_UPD1: begin
                w_cmd.upd = 1'b1;
                w_cmd.pf  = 1'b0;
                if (w_res.mfound) begin
                    w_cmd.idx = w_res.midx;
                    w_cmd.age = w_res.mage;
                end else if (w_res.ifound) begin
                    w_cmd.fill = 1'b1;
                    w_cmd.idx  = w_res.iidx;
                    w_cmd.age  = AGE_MAX;
                end else begin
                    w_cmd.fill = 1'b1;
                    w_cmd.idx  = w_res.bidx;
                    w_cmd.age  = w_res.bage;
                end
            end
            S_TABLE: begin
                w_we = 1'b1;
                if (!w_tmiss) begin
                    w_wdata = {1'b1, r_ip, r_addr, w_diff, w_borrow};
                end
            end
            S_STRIDE: begin
                w_cmd.clear = r_pfcond;
            end
            S_UPD2: begin
                if (!w_res.mfound) begin
                    w_cmd.upd  = 1'b1;
                    w_cmd.fill = 1'b1;
                    w_cmd.pf   = 1'b1;
                    if (w_res.ifound) begin
                        w_cmd.idx = w_res.iidx;
                        w_cmd.age = AGE_MAX;
                    end else begin
                        w_cmd.idx = w_res.bidx;
                        w_cmd.age = w_res.bage;
                    end
                end
            end
            S_WAVE1, S_WAVE2, S_FIN: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_lines     <= SPF_LINES_RESET;
            r_clr       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_lines <= i_cfg_data;
            end
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_cmd.clear) begin
                r_cnt <= '0;
            end else if (r_cnt != CW'(CACHE_LINES)) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == S_FIN && n_state == S_IDLE) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr   <= ADDR_BITS'(i_in_item.load_address);
            r_key    <= ADDR_BITS'(i_in_item.load_address);
            r_ip     <= i_in_item.instr_pointer;
            r_issued <= 1'b0;
            r_paddr  <= '0;
        end
        if (r_state == S_UPD1) begin
            r_dhit <= w_res.mfound;
            r_phit <= w_res.mfound && w_res.mpf;
        end
        if (r_state == S_TABLE) begin
            r_diff   <= w_diff;
            // A nonzero stride that repeats exactly, borrow included.
            r_pfcond <= !w_tmiss && (w_tstride != '0 || w_tborrow)
                        && w_diff == w_tstride && w_borrow == w_tborrow;
        end
        if (r_state == S_STRIDE && r_pfcond) begin
            r_key <= r_addr + r_diff;
        end
        if (r_state == S_UPD2 && !w_res.mfound) begin
            r_issued <= 1'b1;
            r_paddr  <= r_key;
        end
        if (r_state == S_FIN && n_state == S_IDLE) begin
            r_out_item.demand_hit       <= r_dhit;
            r_out_item.prefetch_hit     <= r_phit;
            r_out_item.prefetch_issued  <= r_issued;
            r_out_item.prefetch_address <= SPF_FIELD_W'(r_paddr);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign w_agg[0] = '0;

    for (genvar g = 0; g < CACHE_LINES; g++) begin : g_line
        spf_cell #(
            .CACHE_LINES (CACHE_LINES),
            .ADDR_BITS   (ADDR_BITS),
            .INDEX       (g),
            .CW          (CW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_key     (r_key),
            .i_n_lines (w_n_lines),
            .i_agg     (w_agg[g]),
            .o_agg     (w_agg[g + 1])
        );
    end

    spf_mod #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .TW            (TW)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_ip    (i_in_item.instr_pointer),
        .o_done  (w_mod_done),
        .o_rem   (w_rem)
    );

    spf_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES),
        .AW    (TW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_rem),
        .o_rdata (w_rdata)
    );

`ifndef NO_ASSERTIONS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("item accepted during table clearing");

    a_accept_starts_wave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_WAVE1 && r_cnt == '0))
        else $error("accepted item did not start a lookup wave");

    a_pf_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.prefetch_issued || o_out_item.prefetch_address == '0))
        else $error("prefetch address set without a prefetch");

    a_phit_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_item.prefetch_hit || o_out_item.demand_hit))
        else $error("prefetch hit without a demand hit");

    a_prefetch_after_wave2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD2 && !w_res.mfound) |=> r_issued)
        else $error("prefetch fill not recorded");
`endif

endmodule

@@ verif/tb_stride_prefetcher_lru_cache_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stride_prefetcher_lru_cache_unit
// Self-checking bench for the stride prefetcher and its LRU line cache.
// ----------------------------------------------------------------------------
// Loads are driven over the valid/ready input channel and every result item
// is checked against a behavioural model of the cache and the stride table
// held in a small scoreboard class. The lines_in_use register is changed
// between phases while the block is idle. Directed loads cover stride runs,
// negative strides, address wrap, table conflicts and full caches; the
// random part is mostly strided streams on a few instruction pointers.
// ----------------------------------------------------------------------------

class spf_scoreboard;
    localparam int NL = spf_pkg::SPF_CACHE_LINES;
    localparam int NT = spf_pkg::SPF_TABLE_ENTS;

    logic [47:0] line_addr [NL];
    bit          line_vld  [NL];
    bit          line_pf   [NL];
    int          line_age  [NL];
    logic [47:0] tbl_tag   [NT];
    bit          tbl_vld   [NT];
    logic [47:0] tbl_last  [NT];
    logic [48:0] tbl_stride[NT];
    logic [6:0]  lines_cfg;
    spf_pkg::t_out_item pending[$];
    int errors;
    int mismatches;

    function new();
        for (int i = 0; i < NL; i++) begin
            line_vld[i] = 0; line_pf[i] = 0; line_age[i] = 0; line_addr[i] = '0;
        end
        for (int i = 0; i < NT; i++) begin
            tbl_vld[i] = 0; tbl_tag[i] = '0; tbl_last[i] = '0; tbl_stride[i] = '0;
        end
        lines_cfg = 7'd64;
        errors = 0;
        mismatches = 0;
    endfunction

    function int active_lines();
        if (lines_cfg == 0) return 1;
        if (lines_cfg > NL) return NL;
        return int'(lines_cfg);
    endfunction

    function int lookup_line(logic [47:0] a, int n);
        for (int i = 0; i < n; i++)
            if (line_vld[i] && line_addr[i] == a) return i;
        return -1;
    endfunction

    function void make_recent(int x, int n);
        int a;
        a = line_age[x];
        for (int i = 0; i < n; i++)
            if (i != x && line_vld[i] && line_age[i] < a && line_age[i] < NL - 1)
                line_age[i]++;
        line_age[x] = 0;
    endfunction

    function void fill(logic [47:0] a, bit pf, int n);
        int v;
        bit got;
        v = 0;
        got = 0;
        for (int i = 0; i < n && !got; i++)
            if (!line_vld[i]) begin
                v = i; got = 1;
            end
        if (got) begin
            line_age[v] = NL - 1;
        end else begin
            for (int i = 1; i < n; i++)
                if (line_age[i] > line_age[v]) v = i;
        end
        make_recent(v, n);
        line_addr[v] = a;
        line_vld[v] = 1;
        line_pf[v] = pf;
    endfunction

    function void note_load(spf_pkg::t_in_item it);
        spf_pkg::t_out_item r;
        int n, x, t;
        logic [48:0] diff;
        logic [47:0] nxt;
        n = active_lines();
        t = int'(it.instr_pointer % NT);
        r = '0;
        x = lookup_line(it.load_address, n);
        if (x >= 0) begin
            r.demand_hit = 1;
            if (line_pf[x]) begin
                r.prefetch_hit = 1; line_pf[x] = 0;
            end
            make_recent(x, n);
        end else begin
            fill(it.load_address, 0, n);
        end
        if (!tbl_vld[t] || tbl_tag[t] != it.instr_pointer) begin
            tbl_vld[t] = 1;
            tbl_tag[t] = it.instr_pointer;
            tbl_last[t] = it.load_address;
            tbl_stride[t] = '0;
        end else begin
            // The borrow bit on top makes the stride a signed difference.
            diff = {1'b0, it.load_address} - {1'b0, tbl_last[t]};
            if (tbl_stride[t] != 0 && diff == tbl_stride[t]) begin
                nxt = it.load_address + diff[47:0];
                if (lookup_line(nxt, n) < 0) begin
                    fill(nxt, 1, n);
                    r.prefetch_issued = 1;
                    r.prefetch_address = nxt;
                end
            end
            tbl_last[t] = it.load_address;
            tbl_stride[t] = diff;
        end
        pending = {pending, r};
    endfunction

    function void check_result(spf_pkg::t_out_item got);
        spf_pkg::t_out_item exp_r;
        if (pending.size() == 0) begin
            errors++;
            if (mismatches++ < 10) $display("unexpected result item %p", got);
            return;
        end
        exp_r = pending.pop_front();
        if (got !== exp_r) begin
            errors++;
            if (mismatches++ < 10)
                $display("result mismatch: expected %p, got %p", exp_r, got);
        end
    endfunction
endclass

module tb_stride_prefetcher_lru_cache_unit;
    import spf_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int ITEM_CYCLES = 2 * SPF_CACHE_LINES + 10;

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_ready, o_out_valid, i_out_ready, i_cfg_we;
    t_in_item  i_in_item;
    t_out_item o_out_item;
    logic [SPF_CFG_W-1:0] i_cfg_data;

    int send_idle_pct, recv_idle_pct, quiet_cycles;
    spf_scoreboard sb;

    stride_prefetcher_lru_cache_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_item(o_out_item),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0; #4;
        i_clk = 1'b1; #4;
    end

    // Receiver: ready toggles at the falling edge, results checked at the rising.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_item);
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Valid drops only in idle cycles; a following item takes over directly.
    task automatic send_load(logic [47:0] addr, logic [47:0] ip);
        i_in_valid <= 1'b1;
        i_in_item  <= '{load_address: addr, instr_pointer: ip};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_load(i_in_item);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (ITEM_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_lines(logic [SPF_CFG_W-1:0] v);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.lines_cfg = v;
    endtask

    task automatic stride_run(logic [47:0] base, logic [47:0] step,
                              logic [47:0] ip, int len);
        for (int k = 0; k < len; k++) send_load(base + step * k, ip);
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    task automatic random_phase(int count);
        logic [47:0] ips [4];
        logic [47:0] base, step;
        int left, len;
        for (int i = 0; i < 4; i++) ips[i] = rand48();
        left = count;
        while (left > 0) begin
            case ($urandom_range(9))
                0: begin
                    send_load(rand48(), rand48());
                    left--;
                end
                1: begin
                    send_load({44'h0, 4'($urandom())}, ips[$urandom_range(3)]);
                    left--;
                end
                default: begin
                    // Strided stream, small strides mostly, sometimes negative.
                    len  = $urandom_range(3, 10);
                    step = ($urandom_range(3) == 0) ? rand48()
                                                    : 48'($signed($urandom_range(16)) - 8);
                    base = ($urandom_range(1)) ? rand48() : {40'h0, 8'($urandom())};
                    stride_run(base, step, ips[$urandom_range(3)], len);
                    left -= len;
                end
            endcase
        end
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = SPF_LINES_RESET;
        send_idle_pct = 19;
        recv_idle_pct = 72;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: stride runs, repeats, wrap, negative stride, table conflict.
        stride_run(48'h100, 48'h40, 48'h1000, 4);
        send_load(48'h1c0, 48'h2000);
        send_load(48'h1c0, 48'h2000);
        stride_run(48'hFFFF_FFFF_FFF0, 48'h8, 48'hFFFF_FFFF_FFFF, 4);
        stride_run(48'h0, 48'hFFFF_FFFF_FFFF, 48'h0, 4);
        send_load(48'h500, 48'h1040);
        send_load(48'h500, 48'h1000);
        stride_run(48'h8000_0000_0000, 48'h8000_0000_0000, 48'h7, 3);
        write_lines(7'd1);
        stride_run(48'h10, 48'h10, 48'h55, 4);
        write_lines(7'd0);
        stride_run(48'h20, 48'h20, 48'h55, 3);
        write_lines(7'd127);
        stride_run(48'h40, 48'h40, 48'hAAAA_AAAA_AAAA, 3);

        write_lines(7'd2);
        random_phase(130);
        write_lines(7'd64);
        random_phase(130);
        send_idle_pct = 72;
        recv_idle_pct = 19;
        write_lines(7'd5);
        random_phase(130);
        write_lines(7'($urandom_range(127)));
        random_phase(130);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_lines(7'd16);
        random_phase(130);
        write_lines(7'd64);
        random_phase(130);

        wait_drained();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

@@ stride_prefetcher_lru_cache_unit.f @@
rtl/spf_pkg.sv
rtl/spf_ram.sv
rtl/spf_mod.sv
rtl/spf_cell.sv
rtl/stride_prefetcher_lru_cache_unit.sv
verif/tb_stride_prefetcher_lru_cache_unit.sv
